@@ design/hrn_pkg.sv @@
`timescale 1ns / 1ps
package hrn_pkg;

  localparam int COORD_BITS       = 20;
  localparam int DIFF_W           = COORD_BITS;
  localparam int SQ_W             = 2 * COORD_BITS + 2;
  localparam int ROOT_W           = SQ_W / 2;
  localparam int REM_W            = ROOT_W + 2;
  localparam int SUM_W            = ROOT_W + 2;
  localparam int PROD_W           = 4 * SUM_W;
  localparam int AREA_W           = 34;
  localparam int AREA_FRAC_SHIFT  = 10;
  localparam int ASQ_ROOT_W       = AREA_W + AREA_FRAC_SHIFT;
  localparam int ASQ_W            = 2 * ASQ_ROOT_W;
  localparam int AREM_W           = ASQ_ROOT_W + 2;
  localparam int CFG_W            = 16;
  localparam int LANE_LAT         = 3 + ROOT_W;
  localparam int MERGE_LAT        = 6 + ASQ_ROOT_W;
  localparam int PIPE_LAT         = LANE_LAT + MERGE_LAT;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [ROOT_W-1:0]            root_t;
  typedef logic [AREA_W-1:0]            area_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

endpackage

@@ design/hrn_edge_lane.sv @@
`timescale 1ns / 1ps
module hrn_edge_lane (
  input  logic                     clk,
  input  logic                     en,
  input  hrn_pkg::vec3_t           p,
  input  hrn_pkg::vec3_t           q,
  input  logic [hrn_pkg::CFG_W-1:0] min_edge_sq,
  output hrn_pkg::root_t           root,
  output logic                     deg
);
  import hrn_pkg::*;

  coord_t                  pc [3];
  coord_t                  qc [3];
  logic [DIFF_W-1:0]       ad [3];
  logic [DIFF_W-1:0]       d_r [3];
  logic [2*DIFF_W-1:0]     sq_r [3];
  logic [SQ_W-1:0]         sum_r;

  logic [SQ_W-1:0]         val_r [ROOT_W];
  logic [REM_W-1:0]        rem_r [ROOT_W];
  logic [ROOT_W-1:0]       rt_r  [ROOT_W];
  logic                    dg_r  [ROOT_W];
  logic [SQ_W-1:0]         val_nxt [ROOT_W];
  logic [REM_W-1:0]        rem_nxt [ROOT_W];
  logic [ROOT_W-1:0]       rt_nxt  [ROOT_W];
  logic                    dg_nxt  [ROOT_W];

  assign pc[0] = p.x;
  assign pc[1] = p.y;
  assign pc[2] = p.z;
  assign qc[0] = q.x;
  assign qc[1] = q.y;
  assign qc[2] = q.z;

  always_comb begin
    logic signed [COORD_BITS:0] df;
    for (int i = 0; i < 3; i++) begin
      df = $signed({pc[i][COORD_BITS-1], pc[i]}) - $signed({qc[i][COORD_BITS-1], qc[i]});
      ad[i] = df[COORD_BITS] ? DIFF_W'(-df) : DIFF_W'(df);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]  <= ad[i];
        sq_r[i] <= d_r[i] * d_r[i];
      end
      sum_r <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
    end
  end

  // one root bit per stage
  always_comb begin
    logic [SQ_W-1:0]   vin;
    logic [REM_W-1:0]  rin;
    logic [ROOT_W-1:0] rtin;
    logic [REM_W-1:0]  rsh;
    logic [REM_W-1:0]  trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        vin       = sum_r;
        rin       = '0;
        rtin      = '0;
        dg_nxt[k] = (sum_r <= SQ_W'(min_edge_sq));
      end else begin
        vin       = val_r[k-1];
        rin       = rem_r[k-1];
        rtin      = rt_r[k-1];
        dg_nxt[k] = dg_r[k-1];
      end
      rsh   = {rin[REM_W-3:0], vin[SQ_W-1:SQ_W-2]};
      trial = {rtin, 2'b01};
      if (rsh >= trial) begin
        rem_nxt[k] = rsh - trial;
        rt_nxt[k]  = {rtin[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rsh;
        rt_nxt[k]  = {rtin[ROOT_W-2:0], 1'b0};
      end
      val_nxt[k] = {vin[SQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      rem_r <= rem_nxt;
      rt_r  <= rt_nxt;
      dg_r  <= dg_nxt;
    end
  end

  assign root = rt_r[ROOT_W-1];
  assign deg  = dg_r[ROOT_W-1];

endmodule

@@ design/hrn_merge.sv @@
`timescale 1ns / 1ps
module hrn_merge (
  input  logic           clk,
  input  logic           en,
  input  hrn_pkg::root_t e0,
  input  hrn_pkg::root_t e1,
  input  hrn_pkg::root_t e2,
  input  logic           deg_in,
  output hrn_pkg::area_t area,
  output logic           deg
);
  import hrn_pkg::*;

  root_t               e [3];
  logic [SUM_W-1:0]    f_nxt [4];
  logic [SUM_W-1:0]    f0_r, f1_r, f2a_r, f2b_r, f3a_r, f3b_r, f3c_r, f3d_r;
  logic [2*SUM_W-1:0]  m1_r;
  logic [2*SUM_W-1:0]  pa_lo_r, pa_hi_r;
  logic [3*SUM_W-1:0]  m3_r;
  logic [2*SUM_W-1:0]  pb_r [3];
  logic [PROD_W-1:0]   prod;
  logic [ASQ_W-1:0]    x_r;
  logic                sat_r;
  logic                dgm_r [6];

  logic [ASQ_W-1:0]      val_r [ASQ_ROOT_W];
  logic [AREM_W-1:0]     rem_r [ASQ_ROOT_W];
  logic [ASQ_ROOT_W-1:0] rt_r  [ASQ_ROOT_W];
  logic                  dg_r  [ASQ_ROOT_W];
  logic                  st_r  [ASQ_ROOT_W];
  logic [ASQ_W-1:0]      val_nxt [ASQ_ROOT_W];
  logic [AREM_W-1:0]     rem_nxt [ASQ_ROOT_W];
  logic [ASQ_ROOT_W-1:0] rt_nxt  [ASQ_ROOT_W];
  logic                  dg_nxt  [ASQ_ROOT_W];
  logic                  st_nxt  [ASQ_ROOT_W];

  assign e[0] = e0;
  assign e[1] = e1;
  assign e[2] = e2;

  // doubled Heron factors, negative ones clamp to zero
  always_comb begin
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] tw;
    s = SUM_W'(e[0]) + SUM_W'(e[1]) + SUM_W'(e[2]);
    f_nxt[0] = s;
    for (int i = 0; i < 3; i++) begin
      tw = SUM_W'({e[i], 1'b0});
      f_nxt[i+1] = (tw > s) ? '0 : s - tw;
    end
  end

  always_comb begin
    prod = '0;
    for (int j = 0; j < 3; j++) begin
      prod = prod + (PROD_W'(pb_r[j]) << (j * SUM_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_r     <= f_nxt[0];
      f1_r     <= f_nxt[1];
      f2a_r    <= f_nxt[2];
      f3a_r    <= f_nxt[3];
      dgm_r[0] <= deg_in;

      m1_r     <= f0_r * f1_r;
      f2b_r    <= f2a_r;
      f3b_r    <= f3a_r;
      dgm_r[1] <= dgm_r[0];

      pa_lo_r  <= m1_r[SUM_W-1:0] * f2b_r;
      pa_hi_r  <= m1_r[2*SUM_W-1:SUM_W] * f2b_r;
      f3c_r    <= f3b_r;
      dgm_r[2] <= dgm_r[1];

      m3_r     <= (3*SUM_W)'(pa_lo_r) + ((3*SUM_W)'(pa_hi_r) << SUM_W);
      f3d_r    <= f3c_r;
      dgm_r[3] <= dgm_r[2];

      for (int j = 0; j < 3; j++) begin
        pb_r[j] <= m3_r[j*SUM_W +: SUM_W] * f3d_r;
      end
      dgm_r[4] <= dgm_r[3];

      x_r      <= prod[ASQ_W-1:0];
      sat_r    <= |prod[PROD_W-1:ASQ_W];
      dgm_r[5] <= dgm_r[4];
    end
  end

  always_comb begin
    logic [ASQ_W-1:0]      vin;
    logic [AREM_W-1:0]     rin;
    logic [ASQ_ROOT_W-1:0] rtin;
    logic [AREM_W-1:0]     rsh;
    logic [AREM_W-1:0]     trial;
    for (int k = 0; k < ASQ_ROOT_W; k++) begin
      if (k == 0) begin
        vin       = x_r;
        rin       = '0;
        rtin      = '0;
        dg_nxt[k] = dgm_r[5];
        st_nxt[k] = sat_r;
      end else begin
        vin       = val_r[k-1];
        rin       = rem_r[k-1];
        rtin      = rt_r[k-1];
        dg_nxt[k] = dg_r[k-1];
        st_nxt[k] = st_r[k-1];
      end
      rsh   = {rin[AREM_W-3:0], vin[ASQ_W-1:ASQ_W-2]};
      trial = {rtin, 2'b01};
      if (rsh >= trial) begin
        rem_nxt[k] = rsh - trial;
        rt_nxt[k]  = {rtin[ASQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rsh;
        rt_nxt[k]  = {rtin[ASQ_ROOT_W-2:0], 1'b0};
      end
      val_nxt[k] = {vin[ASQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      rem_r <= rem_nxt;
      rt_r  <= rt_nxt;
      dg_r  <= dg_nxt;
      st_r  <= st_nxt;
    end
  end

  assign deg  = dg_r[ASQ_ROOT_W-1];
  assign area = dg_r[ASQ_ROOT_W-1] ? '0 :
                st_r[ASQ_ROOT_W-1] ? '1 :
                rt_r[ASQ_ROOT_W-1][ASQ_ROOT_W-1:AREA_FRAC_SHIFT];

endmodule

@@ design/triangle_area_heron_3d_core.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   in_ax .. in_cz (signed Q11.8)
// out_      output     out_valid/out_stall out_area, out_degenerate
// cfg_      input      cfg_we              cfg_wdata (min_edge_sq)
//
// one triangle per cycle while out_stall does not freeze the pipeline
// depth mostly from the two bit-per-stage square root pipelines (21 + 44 stages)
// rst_n is synchronous, clears valid flags and min_edge_sq
// out_stall with a waiting result freezes the whole pipeline and raises in_stall
module triangle_area_heron_3d_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  hrn_pkg::coord_t              in_ax,
  input  hrn_pkg::coord_t              in_ay,
  input  hrn_pkg::coord_t              in_az,
  input  hrn_pkg::coord_t              in_bx,
  input  hrn_pkg::coord_t              in_by,
  input  hrn_pkg::coord_t              in_bz,
  input  hrn_pkg::coord_t              in_cx,
  input  hrn_pkg::coord_t              in_cy,
  input  hrn_pkg::coord_t              in_cz,
  output logic                         out_valid,
  input  logic                         out_stall,
  output hrn_pkg::area_t               out_area,
  output logic                         out_degenerate,
  input  logic                         cfg_we,
  input  logic [hrn_pkg::CFG_W-1:0]    cfg_wdata
);
  import hrn_pkg::*;

  logic              en;
  logic [CFG_W-1:0]  min_edge_sq_r;
  logic              vld_r [PIPE_LAT];
  logic              out_valid_r;
  area_t             out_area_r;
  logic              out_deg_r;
  vec3_t             va, vb, vc;
  root_t             e0, e1, e2;
  logic              dg0, dg1, dg2;
  area_t             m_area;
  logic              m_deg;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign va = {in_ax, in_ay, in_az};
  assign vb = {in_bx, in_by, in_bz};
  assign vc = {in_cx, in_cy, in_cz};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_edge_sq_r <= '0;
    end else if (cfg_we) begin
      min_edge_sq_r <= cfg_wdata;
    end
  end

  hrn_edge_lane u_lane_ab (
    .clk(clk), .en(en), .p(va), .q(vb), .min_edge_sq(min_edge_sq_r), .root(e0), .deg(dg0)
  );
  hrn_edge_lane u_lane_cb (
    .clk(clk), .en(en), .p(vc), .q(vb), .min_edge_sq(min_edge_sq_r), .root(e1), .deg(dg1)
  );
  hrn_edge_lane u_lane_ac (
    .clk(clk), .en(en), .p(va), .q(vc), .min_edge_sq(min_edge_sq_r), .root(e2), .deg(dg2)
  );

  hrn_merge u_merge (
    .clk(clk), .en(en), .e0(e0), .e1(e1), .e2(e2),
    .deg_in(dg0 | dg1 | dg2), .area(m_area), .deg(m_deg)
  );

  // transaction valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_area_r <= m_area;
      out_deg_r  <= m_deg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_area       = out_area_r;
  assign out_degenerate = out_deg_r;

endmodule

@@ design/hrn_checker.sv @@
`timescale 1ns / 1ps
module hrn_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input hrn_pkg::area_t            out_area,
  input logic                      out_degenerate
);
  import hrn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_area) && $stable(out_degenerate))
    else $error("stalled result changed");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_area == '0)
    else $error("degenerate triangle with nonzero area");

  a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind triangle_area_heron_3d_core hrn_checker u_hrn_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_area(out_area),
  .out_degenerate(out_degenerate)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import hrn_pkg::*;

  typedef struct {
    logic [AREA_W-1:0] area;
    logic              degenerate;
  } area_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_ax = '0, in_ay = '0, in_az = '0;
  coord_t in_bx = '0, in_by = '0, in_bz = '0;
  coord_t in_cx = '0, in_cy = '0, in_cz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  area_t out_area;
  logic out_degenerate;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [15:0] min_edge_sq_m;
  area_res_t area_q[$];
  int errors = 0;
  int cycles = 0;
  int rx_wait = 0;
  bit rx_idle_en = 1'b1;

  always #4 clk = ~clk;

  triangle_area_heron_3d_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_area(out_area), .out_degenerate(out_degenerate),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [127:0] floor_sqrt(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] b;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      b = r | (128'd1 << i);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  function automatic logic [127:0] edge_sq(coord_t px, coord_t py, coord_t pz,
                                           coord_t qx, coord_t qy, coord_t qz);
    longint dx, dy, dz;
    dx = longint'(px) - longint'(qx);
    dy = longint'(py) - longint'(qy);
    dz = longint'(pz) - longint'(qz);
    return 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
  endfunction

  function automatic area_res_t heron_area(coord_t c[9]);
    area_res_t r;
    logic [127:0] sq[3];
    logic [127:0] e[3];
    logic [127:0] s, f1, f2, f3, prod;
    sq[0] = edge_sq(c[0], c[1], c[2], c[3], c[4], c[5]);
    sq[1] = edge_sq(c[6], c[7], c[8], c[3], c[4], c[5]);
    sq[2] = edge_sq(c[0], c[1], c[2], c[6], c[7], c[8]);
    r.area = '0;
    r.degenerate = 1'b0;
    if (sq[0] <= min_edge_sq_m || sq[1] <= min_edge_sq_m || sq[2] <= min_edge_sq_m) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) e[i] = floor_sqrt(sq[i]);
    s = e[0] + e[1] + e[2];
    f1 = (2 * e[0] > s) ? 0 : s - 2 * e[0];
    f2 = (2 * e[1] > s) ? 0 : s - 2 * e[1];
    f3 = (2 * e[2] > s) ? 0 : s - 2 * e[2];
    prod = s * f1 * f2 * f3;
    if (prod >= (128'd1 << 88)) r.area = '1;
    else begin
      prod = floor_sqrt(prod) >> 10;
      r.area = (prod > {AREA_W{1'b1}}) ? '1 : prod[AREA_W-1:0];
    end
    return r;
  endfunction

  task automatic send_triangle(coord_t c[9]);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_ax, in_ay, in_az} <= {c[0], c[1], c[2]};
    {in_bx, in_by, in_bz} <= {c[3], c[4], c[5]};
    {in_cx, in_cy, in_cz} <= {c[6], c[7], c[8]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    area_q.push_back(heron_area(c));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (area_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic write_min_edge_sq(logic [15:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_edge_sq_m = v;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 512) - 256);
      2: return coord_t'($urandom_range(0, 1)) ? 20'sh7ffff : 20'sh80000;
      default: return coord_t'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  task automatic send_random(int n);
    coord_t c[9];
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
      case ($urandom_range(0, 9))
        0: for (int i = 0; i < 3; i++) c[3+i] = c[i];
        1: for (int i = 0; i < 3; i++) c[6+i] = coord_t'(c[i] + 2 * (c[3+i] - c[i]));
        2: for (int i = 0; i < 3; i++) c[3+i] = coord_t'(c[i] + $urandom_range(0, 2) - 1);
        default: ;
      endcase
      send_triangle(c);
    end
  endtask

  task automatic test_directed();
    coord_t c[9];
    coord_t mx, mn;
    mx = 20'sh7ffff;
    mn = 20'sh80000;
    c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    c = '{mn, mn, mn, mx, mx, mx, mn, mx, mn};
    send_triangle(c);
    c = '{mn, mn, 0, mx, mn, 0, mn, mx, 0};
    send_triangle(c);
    c = '{mx, mx, mx, mn, mn, mn, mx, mn, mx};
    send_triangle(c);
    c = '{5, 5, 5, 5, 5, 5, 9, 9, 9};
    send_triangle(c);
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(c);
    c = '{0, 0, 0, 256, 0, 0, 512, 0, 0};
    send_triangle(c);
    c = '{0, 0, 0, 1000, 1, 0, 2000, 0, 0};
    send_triangle(c);
    c = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
    send_triangle(c);
    c = '{mn, 0, 0, mx, 0, 0, 0, mx, mn};
    send_triangle(c);
  endtask

  task automatic test_threshold();
    coord_t c[9];
    write_min_edge_sq(16'hffff);
    c = '{0, 0, 0, 255, 0, 0, 0, 255, 0};
    send_triangle(c);
    c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    send_random(100);
    write_min_edge_sq(16'd1);
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(c);
    send_random(100);
    write_min_edge_sq(16'($urandom));
    send_random(100);
    write_min_edge_sq(16'd0);
  endtask

  task automatic test_backpressure();
    rx_idle_en = 1'b0;
    send_random(50);
    wait_drain();
    rx_idle_en = 1'b1;
    send_random(50);
  endtask

  always @(posedge clk) begin
    area_res_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (area_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          exp_r = area_q.pop_front();
          if (out_area !== exp_r.area) begin
            $error("area expected %0d actual %0d", exp_r.area, out_area);
            errors++;
          end
          if (out_degenerate !== exp_r.degenerate) begin
            $error("degenerate expected %0d actual %0d", exp_r.degenerate, out_degenerate);
            errors++;
          end
        end
        rx_wait = rx_idle_en ? int'($urandom_range(0, 6)) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    min_edge_sq_m = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_threshold();
    send_random(800);
    test_backpressure();
    wait_drain();
    if (errors == 0 && area_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ triangle_area_heron_3d_core.f @@
design/hrn_pkg.sv
design/hrn_edge_lane.sv
design/hrn_merge.sv
design/triangle_area_heron_3d_core.sv
design/hrn_checker.sv
dv/tb_top.sv
